@@ rtl/core/pfla_pkg.sv @@
package pfla_pkg;

    localparam int DefPoolDepth  = 4096;
    localparam int HeaderBytes   = 16;
    localparam int CfgW          = 12;
    localparam int BytesW        = 16;
    localparam int QW            = 17;
    localparam int DivSh         = 24;
    localparam int DivMul        = ((1 << DivSh) + HeaderBytes - 1) / HeaderBytes;
    localparam int DivMulW       = $clog2(DivMul + 1);
    localparam int DivInW        = BytesW + 1;
    localparam logic [11:0] DefPoolQuanta = 12'd4095;
    localparam logic [11:0] DefMinGrow    = 12'd16;

    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_MEM    = 2'd1;
    localparam logic [1:0] ST_NOT_READY = 2'd2;

    localparam logic REG_POOL_QUANTA = 1'b0;
    localparam logic REG_MIN_GROW    = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DEC,
        S_DIV1,
        S_DIV2,
        S_A_RD,
        S_A_GETP,
        S_A_CHK,
        S_A_SPLIT,
        S_A_RESUME,
        S_R_CHK,
        S_R_F2,
        S_R_F3,
        S_R_F4,
        S_DONE
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_REL_EARLY,
        OP_R_CMD,
        OP_DIV1,
        OP_DIV2,
        OP_A_RDPREV,
        OP_A_GETP,
        OP_A_EXACT,
        OP_A_SPLIT1,
        OP_A_SPLIT2,
        OP_A_GROW,
        OP_A_FAIL,
        OP_A_STEP,
        OP_A_RESUME,
        OP_R_STEP,
        OP_R_F1,
        OP_R_F2,
        OP_R_F3,
        OP_R_F4
    } t_op;

    typedef struct packed {
        t_op  op;
        logic ready;
        logic done;
    } t_cmd;

    typedef struct packed {
        logic is_alloc;
        logic started;
        logic rel_ok;
        logic hit;
        logic exact;
        logic at_search;
        logic grow_fail;
        logic alloc_cap;
        logic rel_found;
        logic rel_cap;
        logic from_grow;
    } t_dp_stat;

endpackage

@@ rtl/core/pool_free_list_allocator_unit.sv @@
// Next-fit free-list allocator over a pool of header-sized quanta.
// Input items arrive on s_axis: tuser carries the command (0 allocate,
// 1 release), tdata the byte count and the data index to release.
// Each item gives one result item on m_axis: granted data index and status.
// Configuration (pool size, least growth) is to be written through i_cfg_*
// only while the block is idle, which the block does not enforce itself;
// writes take effect at once. An allocate turns the bytes into quanta
// and walks the list from the search position to an entry that fits
// exactly or is split; back at the search position it grows the pool by
// releasing a new block and resumes. A release walks to its insertion
// point and links the block in; one before any allocate or of the
// sentinel goes straight to the result. The walk through the link/size
// memories, one read per cycle, sets the rate; one item is in work at a
// time, the next is accepted the cycle after the result is registered.
// Reset empties the list state; memories need no clearing pass.
// A finished result waits in the output register while the next item is
// accepted; if the receiver stalls, the block holds its next result until
// the output register is free.
module pool_free_list_allocator_unit
    import pfla_pkg::*;
#(
    parameter int POOL_DEPTH = DefPoolDepth,
    localparam int IW    = $clog2(POOL_DEPTH),
    localparam int IN_W  = ((BytesW + IW + 7) / 8) * 8,
    localparam int OUT_W = ((IW + 2 + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,   // request_bytes, release_index
    input  logic             s_axis_tuser,   // command
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata,   // data_index, status
    input  logic             i_cfg_we,
    input  logic             i_cfg_addr,
    input  logic [CfgW-1:0]  i_cfg_wdata
);

    t_cmd          cmd;
    t_dp_stat      stat;
    logic          out_free;
    logic [IW-1:0] dp_data;
    logic [1:0]    dp_status;
    logic          r_ovalid;
    logic [IW-1:0] r_odata;
    logic [1:0]    r_ostatus;

    assign out_free = !r_ovalid || m_axis_tready;

    pfla_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_out_free (out_free),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    pfla_dp #(.POOL_DEPTH(POOL_DEPTH)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_cmd    (s_axis_tuser),
        .i_in_bytes  (s_axis_tdata[BytesW-1:0]),
        .i_in_rel    (s_axis_tdata[BytesW+IW-1:BytesW]),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_stat      (stat),
        .o_data      (dp_data),
        .o_status    (dp_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (cmd.done) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.done) begin
            r_odata   <= dp_data;
            r_ostatus <= dp_status;
        end
    end

    assign s_axis_tready = cmd.ready;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = OUT_W'({r_ostatus, r_odata});

endmodule

@@ rtl/core/pfla_ctrl.sv @@
module pfla_ctrl
    import pfla_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_out_free,
    input  t_dp_stat i_stat,
    output t_cmd     o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DEC;
            end
            S_DEC: begin
                if (i_stat.is_alloc) n_state = S_DIV1;
                else if (!i_stat.started || !i_stat.rel_ok) n_state = S_DONE;
                else n_state = S_R_CHK;
            end
            S_DIV1:   n_state = S_DIV2;
            S_DIV2:   n_state = S_A_RD;
            S_A_RD:   n_state = S_A_GETP;
            S_A_GETP: n_state = S_A_CHK;
            S_A_CHK: begin
                if (i_stat.hit && i_stat.exact) n_state = S_DONE;
                else if (i_stat.hit) n_state = S_A_SPLIT;
                else if (i_stat.at_search) n_state = i_stat.grow_fail ? S_DONE : S_R_CHK;
                else if (i_stat.alloc_cap) n_state = S_DONE;
                else n_state = S_A_CHK;
            end
            S_A_SPLIT:  n_state = S_DONE;
            S_A_RESUME: n_state = i_stat.alloc_cap ? S_DONE : S_A_GETP;
            S_R_CHK: begin
                if (i_stat.rel_found) n_state = S_R_F2;
                else if (i_stat.rel_cap) n_state = i_stat.from_grow ? S_A_RESUME : S_DONE;
                else n_state = S_R_CHK;
            end
            S_R_F2: n_state = S_R_F3;
            S_R_F3: n_state = S_R_F4;
            S_R_F4: n_state = i_stat.from_grow ? S_A_RESUME : S_DONE;
            S_DONE: begin
                if (i_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.op    = OP_NONE;
        o_cmd.ready = 1'b0;
        o_cmd.done  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_cmd.ready = 1'b1;
                if (i_in_valid) o_cmd.op = OP_LOAD;
            end
            S_DEC: begin
                if (i_stat.is_alloc) o_cmd.op = OP_NONE;
                else if (!i_stat.started || !i_stat.rel_ok) o_cmd.op = OP_REL_EARLY;
                else o_cmd.op = OP_R_CMD;
            end
            S_DIV1:   o_cmd.op = OP_DIV1;
            S_DIV2:   o_cmd.op = OP_DIV2;
            S_A_RD:   o_cmd.op = OP_A_RDPREV;
            S_A_GETP: o_cmd.op = OP_A_GETP;
            S_A_CHK: begin
                if (i_stat.hit && i_stat.exact) o_cmd.op = OP_A_EXACT;
                else if (i_stat.hit) o_cmd.op = OP_A_SPLIT1;
                else if (i_stat.at_search) o_cmd.op = i_stat.grow_fail ? OP_A_FAIL : OP_A_GROW;
                else if (i_stat.alloc_cap) o_cmd.op = OP_A_FAIL;
                else o_cmd.op = OP_A_STEP;
            end
            S_A_SPLIT:  o_cmd.op = OP_A_SPLIT2;
            S_A_RESUME: o_cmd.op = i_stat.alloc_cap ? OP_A_FAIL : OP_A_RESUME;
            S_R_CHK: begin
                if (i_stat.rel_found) o_cmd.op = OP_R_F1;
                else if (i_stat.rel_cap) o_cmd.op = OP_NONE;
                else o_cmd.op = OP_R_STEP;
            end
            S_R_F2: o_cmd.op = OP_R_F2;
            S_R_F3: o_cmd.op = OP_R_F3;
            S_R_F4: o_cmd.op = OP_R_F4;
            S_DONE: o_cmd.done = i_out_free;
            default: o_cmd.op = OP_NONE;
        endcase
    end

endmodule

@@ rtl/core/pfla_dp.sv @@
module pfla_dp
    import pfla_pkg::*;
#(
    parameter int POOL_DEPTH = DefPoolDepth,
    localparam int IW = $clog2(POOL_DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic              i_in_cmd,
    input  logic [BytesW-1:0] i_in_bytes,
    input  logic [IW-1:0]     i_in_rel,
    input  logic              i_cfg_we,
    input  logic              i_cfg_addr,
    input  logic [CfgW-1:0]   i_cfg_wdata,
    output t_dp_stat          o_stat,
    output logic [IW-1:0]     o_data,
    output logic [1:0]        o_status
);

    localparam int WW    = ((IW > QW) ? IW : QW) + 2;
    localparam int PW    = DivInW + DivMulW;
    localparam int ACap  = 4 * POOL_DEPTH + 8;
    localparam int ASW   = $clog2(ACap);

    logic [IW-1:0] link_mem [POOL_DEPTH];
    logic [IW-1:0] size_mem [POOL_DEPTH];

    logic              r_cmd;
    logic [BytesW-1:0] r_bytes;
    logic [IW-1:0]     r_rel;
    logic [PW-1:0]     r_prod;
    logic [QW-1:0]     r_q;
    logic [IW-1:0]     r_p, r_prev, r_n, r_blk, r_blink, r_bsz, r_search;
    logic              r_started, r_from_grow;
    logic [IW:0]       r_grow;
    logic [ASW-1:0]    r_steps;
    logic [IW:0]       r_rsteps;
    logic [IW-1:0]     r_data;
    logic [1:0]        r_stat;
    logic [CfgW-1:0]   r_pool_quanta, r_min_grow;
    logic [IW-1:0]     r_lk, r_sz;

    logic [IW-1:0] rd_addr;
    logic          link_we, size_we;
    logic [IW-1:0] link_wa, link_wd, size_wa, size_wd;

    logic [WW-1:0] sz_w, q_w, mg_w, g_w, pq1_w, lim_w;
    logic [IW-1:0] rem, split_p, nb, bl;
    logic          merge_n, merge_p;

    assign sz_w    = WW'(r_sz);
    assign q_w     = WW'(r_q);
    assign mg_w    = WW'(r_min_grow);
    assign g_w     = (q_w > mg_w) ? q_w : mg_w;
    assign pq1_w   = WW'(r_pool_quanta) + WW'(1);
    assign lim_w   = (pq1_w > WW'(POOL_DEPTH)) ? WW'(POOL_DEPTH) : pq1_w;
    assign rem     = r_sz - r_q[IW-1:0];
    assign split_p = r_p + rem;
    assign merge_n = (WW'(r_blk) + WW'(r_bsz)) == WW'(r_n);
    assign nb      = merge_n ? (r_bsz + r_sz) : r_bsz;
    assign bl      = merge_n ? r_lk : r_n;
    assign merge_p = (WW'(r_p) + WW'(r_sz)) == WW'(r_blk);

    always_comb begin
        o_stat.is_alloc  = (r_cmd == CMD_ALLOC);
        o_stat.started   = r_started;
        o_stat.rel_ok    = (r_rel >= IW'(2));
        o_stat.hit       = (sz_w >= q_w);
        o_stat.exact     = (sz_w == q_w);
        o_stat.at_search = (r_p == r_search);
        o_stat.grow_fail = (WW'(r_grow) + g_w) > lim_w;
        o_stat.alloc_cap = (r_steps == ASW'(ACap - 1));
        o_stat.rel_found = ((r_blk > r_p) && (r_blk < r_lk))
                        || ((r_p >= r_lk) && ((r_blk > r_p) || (r_blk < r_lk)));
        o_stat.rel_cap   = (r_rsteps == (IW + 1)'(POOL_DEPTH));
        o_stat.from_grow = r_from_grow;
    end

    always_comb begin
        rd_addr = r_p;
        link_we = 1'b0;
        link_wa = r_p;
        link_wd = r_lk;
        size_we = 1'b0;
        size_wa = r_p;
        size_wd = rem;
        case (i_cmd.op)
            OP_DIV1: begin
                link_we = !r_started;
                link_wa = '0;
                link_wd = '0;
                size_we = !r_started;
                size_wa = '0;
                size_wd = '0;
            end
            OP_A_RDPREV, OP_A_RESUME, OP_R_CMD: rd_addr = r_search;
            OP_A_GETP, OP_A_STEP, OP_R_STEP: rd_addr = r_lk;
            OP_A_EXACT: begin
                link_we = 1'b1;
                link_wa = r_prev;
                link_wd = r_lk;
            end
            OP_A_SPLIT1: size_we = 1'b1;
            OP_A_SPLIT2: begin
                size_we = 1'b1;
                size_wd = r_q[IW-1:0];
            end
            OP_A_GROW: begin
                rd_addr = r_search;
                size_we = 1'b1;
                size_wa = r_grow[IW-1:0];
                size_wd = g_w[IW-1:0];
            end
            OP_R_F1: rd_addr = r_blk;
            OP_R_F2: rd_addr = r_n;
            OP_R_F3: begin
                rd_addr = r_p;
                link_we = 1'b1;
                link_wa = r_blk;
                link_wd = bl;
                size_we = 1'b1;
                size_wa = r_blk;
                size_wd = nb;
            end
            OP_R_F4: begin
                link_we = 1'b1;
                link_wa = r_p;
                link_wd = merge_p ? r_blink : r_blk;
                size_we = merge_p;
                size_wa = r_p;
                size_wd = r_sz + r_bsz;
            end
            default: rd_addr = r_p;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (link_we) link_mem[link_wa] <= link_wd;
        if (size_we) size_mem[size_wa] <= size_wd;
        r_lk <= link_mem[rd_addr];
        r_sz <= size_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_search      <= '0;
            r_started     <= 1'b0;
            r_grow        <= (IW + 1)'(1);
            r_pool_quanta <= DefPoolQuanta;
            r_min_grow    <= DefMinGrow;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_addr == REG_POOL_QUANTA) r_pool_quanta <= i_cfg_wdata;
                else r_min_grow <= i_cfg_wdata;
            end
            case (i_cmd.op)
                OP_DIV1: begin
                    if (!r_started) r_search <= '0;
                    r_started <= 1'b1;
                end
                OP_A_EXACT, OP_A_SPLIT1: r_search <= r_prev;
                OP_A_GROW: r_grow <= r_grow + g_w[IW:0];
                OP_R_F4: r_search <= r_p;
                default: r_started <= r_started;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_cmd   <= i_in_cmd;
                r_bytes <= i_in_bytes;
                r_rel   <= i_in_rel;
            end
            OP_REL_EARLY: begin
                r_data <= '0;
                r_stat <= r_started ? ST_OK : ST_NOT_READY;
            end
            OP_R_CMD: begin
                r_blk       <= r_rel - IW'(1);
                r_from_grow <= 1'b0;
                r_p         <= r_search;
                r_rsteps    <= '0;
                r_data      <= '0;
                r_stat      <= ST_OK;
            end
            OP_DIV1: begin
                r_prod  <= PW'(DivInW'(r_bytes) + DivInW'(HeaderBytes - 1))
                         * PW'(DivMul);
                r_steps <= '0;
            end
            OP_DIV2: r_q <= QW'(r_prod >> DivSh) + QW'(1);
            OP_A_RDPREV: r_prev <= r_search;
            OP_A_GETP: r_p <= r_lk;
            OP_A_EXACT: begin
                r_data <= r_p + IW'(1);
                r_stat <= ST_OK;
            end
            OP_A_SPLIT1: r_p <= split_p;
            OP_A_SPLIT2: begin
                r_data <= r_p + IW'(1);
                r_stat <= ST_OK;
            end
            OP_A_GROW: begin
                r_blk       <= r_grow[IW-1:0];
                r_from_grow <= 1'b1;
                r_p         <= r_search;
                r_rsteps    <= '0;
            end
            OP_A_FAIL: begin
                r_data <= '0;
                r_stat <= ST_NO_MEM;
            end
            OP_A_STEP: begin
                r_prev  <= r_p;
                r_p     <= r_lk;
                r_steps <= r_steps + ASW'(1);
            end
            OP_A_RESUME: begin
                r_prev  <= r_search;
                r_steps <= r_steps + ASW'(1);
            end
            OP_R_STEP: begin
                r_p      <= r_lk;
                r_rsteps <= r_rsteps + (IW + 1)'(1);
            end
            OP_R_F1: r_n <= r_lk;
            OP_R_F2: r_bsz <= r_sz;
            OP_R_F3: begin
                r_bsz   <= nb;
                r_blink <= bl;
            end
            default: r_q <= r_q;
        endcase
    end

    assign o_data   = r_data;
    assign o_status = r_stat;

endmodule
